@@ src/ncm_pkg.sv @@
`timescale 1ns / 1ps

package ncm_pkg;

    // Table geometry
    localparam int TILE_DEPTH = 256;
    localparam int IDX_W      = 8;
    localparam int COUNT_W    = 9;
    localparam int COLOR_W    = 8;
    localparam int RGB_W      = 3 * COLOR_W;
    localparam int SQ_W       = 2 * COLOR_W;
    localparam int DIST_W     = 18;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Distance metrics
    localparam logic [MODE_W-1:0] METRIC_EUCLID_SQ = 2'd0;
    localparam logic [MODE_W-1:0] METRIC_MANHATTAN = 2'd1;
    localparam logic [MODE_W-1:0] METRIC_MAX_CHAN  = 2'd2;
    localparam logic [MODE_W-1:0] METRIC_UNUSED    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT  = 2'd2;

    // Request commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic             load_we;
        logic             query_start;
        logic             issue;
        logic [IDX_W-1:0] addr;
        logic             publish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic busy;
    } t_dp_stat;

endpackage

@@ src/ncm_datapath.sv @@
`timescale 1ns / 1ps

// Tile colour memory, distance pipeline, best-match tracking and result register.
module ncm_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ncm_pkg::t_dp_cmd                      i_cmd,
    output ncm_pkg::t_dp_stat                     o_stat,
    input  logic [ncm_pkg::MODE_W-1:0]            i_metric_mode,
    input  logic [ncm_pkg::DIST_W-1:0]            i_match_limit,
    input  logic [ncm_pkg::IDX_W-1:0]             i_entry_index,
    input  logic [ncm_pkg::COLOR_W-1:0]           i_red,
    input  logic [ncm_pkg::COLOR_W-1:0]           i_green,
    input  logic [ncm_pkg::COLOR_W-1:0]           i_blue,
    output logic                                  o_found,
    output logic [ncm_pkg::IDX_W-1:0]             o_best_index,
    output logic [ncm_pkg::DIST_W-1:0]            o_best_distance
);

    logic [ncm_pkg::RGB_W-1:0]   r_tile_mem [ncm_pkg::TILE_DEPTH];
    logic [ncm_pkg::RGB_W-1:0]   r_rd_data;
    logic [ncm_pkg::RGB_W-1:0]   r_query;

    logic                        r_v1, r_v2, r_v3, r_v4;
    logic [ncm_pkg::IDX_W-1:0]   r_idx1, r_idx2, r_idx3, r_idx4;
    logic [ncm_pkg::COLOR_W-1:0] r_dr, r_dg, r_db;
    logic [ncm_pkg::SQ_W-1:0]    r_p0, r_p1, r_p2;
    logic [ncm_pkg::SQ_W-1:0]    n_p0, n_p1, n_p2;
    logic [ncm_pkg::DIST_W-1:0]  r_dist, n_dist;
    logic [ncm_pkg::SQ_W-1:0]    n_max01;

    logic                        r_hit;
    logic [ncm_pkg::IDX_W-1:0]   r_best_idx;
    logic [ncm_pkg::DIST_W-1:0]  r_best_dist;

    logic                        r_found;
    logic [ncm_pkg::IDX_W-1:0]   r_out_idx;
    logic [ncm_pkg::DIST_W-1:0]  r_out_dist;

    function automatic logic [ncm_pkg::COLOR_W-1:0] abs_diff(
        input logic [ncm_pkg::COLOR_W-1:0] a,
        input logic [ncm_pkg::COLOR_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Single-port table: a load writes, the scan reads with a registered output.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_tile_mem[i_entry_index] <= {i_red, i_green, i_blue};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_tile_mem[i_cmd.addr];
        end
        if (i_cmd.query_start) begin
            r_query <= {i_red, i_green, i_blue};
        end
    end

    // Per-channel terms: squares for the Euclidean metric, plain differences otherwise.
    always_comb begin
        if (i_metric_mode == ncm_pkg::METRIC_EUCLID_SQ) begin
            n_p0 = ncm_pkg::SQ_W'(r_dr) * ncm_pkg::SQ_W'(r_dr);
            n_p1 = ncm_pkg::SQ_W'(r_dg) * ncm_pkg::SQ_W'(r_dg);
            n_p2 = ncm_pkg::SQ_W'(r_db) * ncm_pkg::SQ_W'(r_db);
        end else begin
            n_p0 = ncm_pkg::SQ_W'(r_dr);
            n_p1 = ncm_pkg::SQ_W'(r_dg);
            n_p2 = ncm_pkg::SQ_W'(r_db);
        end
    end

    always_comb begin
        n_max01 = (r_p1 > r_p0) ? r_p1 : r_p0;
        unique case (i_metric_mode)
            ncm_pkg::METRIC_EUCLID_SQ,
            ncm_pkg::METRIC_MANHATTAN: begin
                n_dist = ncm_pkg::DIST_W'(r_p0) + ncm_pkg::DIST_W'(r_p1)
                       + ncm_pkg::DIST_W'(r_p2);
            end
            ncm_pkg::METRIC_MAX_CHAN: begin
                n_dist = ncm_pkg::DIST_W'((r_p2 > n_max01) ? r_p2 : n_max01);
            end
            ncm_pkg::METRIC_UNUSED: begin
                n_dist = '0;
            end
        endcase
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_idx1 <= i_cmd.addr;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_idx4 <= r_idx3;
        r_dr   <= abs_diff(r_rd_data[23:16], r_query[23:16]);
        r_dg   <= abs_diff(r_rd_data[15:8],  r_query[15:8]);
        r_db   <= abs_diff(r_rd_data[7:0],   r_query[7:0]);
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_dist <= n_dist;
    end

    // Best match so far; entries arrive in descending order, so a tie keeps the higher index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.query_start) begin
            r_hit <= 1'b0;
        end else if (r_v4 && (r_dist < r_best_dist)) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_best_dist <= i_match_limit;
            r_best_idx  <= '0;
        end else if (r_v4 && (r_dist < r_best_dist)) begin
            r_best_dist <= r_dist;
            r_best_idx  <= r_idx4;
        end
    end

    // Result register, loaded once the scan has drained.
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_found    <= r_hit;
            r_out_idx  <= r_hit ? r_best_idx  : '0;
            r_out_dist <= r_hit ? r_best_dist : '0;
        end
    end

    assign o_stat.busy     = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_found         = r_found;
    assign o_best_index    = r_out_idx;
    assign o_best_distance = r_out_dist;

endmodule

@@ src/ncm_ctrl.sv @@
`timescale 1ns / 1ps

// Sequencer: takes requests, walks the scan address down and hands results out.
module ncm_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_command,
    input  logic [ncm_pkg::COUNT_W-1:0]    i_tile_count,
    output logic                           o_valid,
    input  logic                           i_stall,
    output ncm_pkg::t_dp_cmd               o_cmd,
    input  ncm_pkg::t_dp_stat              i_stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUBLISH
    } t_state;

    t_state                        r_state;
    logic [ncm_pkg::COUNT_W-1:0]   r_left;
    logic                          r_out_valid;

    logic [ncm_pkg::COUNT_W-1:0]   n_eff_count;
    logic [ncm_pkg::COUNT_W-1:0]   n_addr_full;
    logic                          n_accept;
    logic                          n_publish;

    assign n_eff_count = (i_tile_count > ncm_pkg::COUNT_W'(ncm_pkg::TILE_DEPTH))
                       ? ncm_pkg::COUNT_W'(ncm_pkg::TILE_DEPTH) : i_tile_count;
    assign n_addr_full = r_left - ncm_pkg::COUNT_W'(1);
    assign n_accept    = (r_state == ST_IDLE) && i_valid;
    assign n_publish   = (r_state == ST_PUBLISH) && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_publish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept && (i_command == ncm_pkg::CMD_QUERY)) begin
                        r_left  <= n_eff_count;
                        r_state <= (n_eff_count == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_left <= n_addr_full;
                    if (r_left == ncm_pkg::COUNT_W'(1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!i_stat.busy) begin
                        r_state <= ST_PUBLISH;
                    end
                end
                ST_PUBLISH: begin
                    if (n_publish) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load_we     = n_accept && (i_command == ncm_pkg::CMD_LOAD);
        o_cmd.query_start = n_accept && (i_command == ncm_pkg::CMD_QUERY);
        o_cmd.issue       = (r_state == ST_SCAN);
        o_cmd.addr        = n_addr_full[ncm_pkg::IDX_W-1:0];
        o_cmd.publish     = n_publish;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ src/nearest_color_tile_match.sv @@
`timescale 1ns / 1ps

// Channel   | Handshake          | Payload
// ----------+--------------------+----------------------------------------------------
// request   | i_valid / o_stall  | i_command, i_entry_index, i_red, i_green, i_blue
// result    | o_valid / i_stall  | o_found, o_best_index, o_best_distance
// config    | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A query reads min(tile_count, 256) table entries, one per cycle, in descending order;
// the pipeline (table read, channel differences, per-channel terms, distance sum) drains,
// the sequencer waits until it is idle, and then the result register is loaded.
// Reset is synchronous and active low; it clears control state and the configuration
// registers, while the tile table stays undefined until written.
// A stalled result is held in its register; loads and a following query's scan still run.

module nearest_color_tile_match (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_we,
    input  logic [ncm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ncm_pkg::CFG_DATA_W-1:0]      i_cfg_data,

    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [ncm_pkg::IDX_W-1:0]           i_entry_index,
    input  logic [ncm_pkg::COLOR_W-1:0]         i_red,
    input  logic [ncm_pkg::COLOR_W-1:0]         i_green,
    input  logic [ncm_pkg::COLOR_W-1:0]         i_blue,

    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_found,
    output logic [ncm_pkg::IDX_W-1:0]           o_best_index,
    output logic [ncm_pkg::DIST_W-1:0]          o_best_distance
);

    // Configuration registers. The user must write them only while the block is idle; the
    // block does not enforce this; the scan reads them directly, without a shadow copy.
    logic [ncm_pkg::MODE_W-1:0]   r_metric_mode;
    logic [ncm_pkg::DIST_W-1:0]   r_match_limit;
    logic [ncm_pkg::COUNT_W-1:0]  r_tile_count;

    ncm_pkg::t_dp_cmd             w_cmd;
    ncm_pkg::t_dp_stat            w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric_mode <= '0;
            r_match_limit <= '0;
            r_tile_count  <= '0;
        end else if (i_cfg_we) begin
            // A write to an index beyond the register list is dropped.
            unique case (i_cfg_index)
                ncm_pkg::REG_METRIC_MODE: r_metric_mode <= i_cfg_data[ncm_pkg::MODE_W-1:0];
                ncm_pkg::REG_MATCH_LIMIT: r_match_limit <= i_cfg_data[ncm_pkg::DIST_W-1:0];
                ncm_pkg::REG_TILE_COUNT:  r_tile_count  <= i_cfg_data[ncm_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The controller sequences requests and the scan; the datapath owns the table,
    // the distance pipeline and the result payload.
    ncm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_tile_count (r_tile_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    ncm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_metric_mode   (r_metric_mode),
        .i_match_limit   (r_match_limit),
        .i_entry_index   (i_entry_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_found         (o_found),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance)
    );

endmodule
